FILE: rtl/pidsr_pkg.sv
// Shared constants, register codes and widths for the PID speed regulator.
package pidsr_pkg;

  // field and register widths
  localparam int MEAS_W     = 16;
  localparam int SETP_W     = 16;
  localparam int DRIVE_W    = 32;
  localparam int GAIN_W     = 24;
  localparam int ILIM_W     = 20;
  localparam int DLIM_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // datapath widths
  localparam int ERR_W    = MEAS_W + 1;           // setpoint - measured
  localparam int DERR_W   = ERR_W + 1;            // err - previous err
  localparam int ESUM_W   = 24;                   // error integral
  localparam int PROD_P_W = GAIN_W + 1 + DERR_W;  // gain x 18-bit operand
  localparam int PROD_I_W = GAIN_W + 1 + ESUM_W;  // gain x 24-bit operand
  localparam int PSUM_W   = PROD_I_W + 1;         // sum of three products

  // register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LAW_SELECT     = 3'd0,
    REG_SETPOINT       = 3'd1,
    REG_GAIN_P         = 3'd2,
    REG_GAIN_I         = 3'd3,
    REG_GAIN_D         = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_DRIVE_LIMIT    = 3'd6
  } cfg_reg_t;

  // control laws
  localparam logic LAW_POSITIONAL  = 1'b0;
  localparam logic LAW_INCREMENTAL = 1'b1;

  // register reset values
  localparam logic [SETP_W-1:0] SETPOINT_RST  = 16'd50;
  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 24'd524288;  // 8.0 in Q8.16
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 24'd32768;   // 0.5 in Q8.16
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 24'd0;
  localparam logic [ILIM_W-1:0] ILIM_RST      = 20'd7200;
  localparam logic [DLIM_W-1:0] DLIM_RST      = 16'd719;

endpackage

FILE: rtl/pid_speed_regulator_top.sv
// PID speed regulator: positional PID with clamps or incremental PI, fully pipelined.
//
// Usage:
//   in_*  : one measured sample per transaction (in_tdata[15:0], signed).
//   out_* : one drive value per input transaction, same order.
//           out_tdata = drive (32-bit signed), out_tuser = clamped flag.
//   cfg_* : plain write port; cfg_addr selects the register, written on any
//           edge with cfg_we high. Unused indexes are ignored. Write only
//           while the pipeline is empty.
// Pipeline: operand, product, product sum and output registers, in that order;
//   the operand register loads on the accepting edge.
// Throughput: one transaction per cycle while the output is not stalled. The
//   loop-carried state (error integral, previous error) is updated at the
//   input stage with an add and a compare; the incremental total closes its
//   loop in the output stage with one wide add, a rounding add and a saturate.
// Stall: each stage advances when the stage after it is empty or moving,
//   so bubbles collapse and input is still taken while a result waits, if a stage is empty.
// Reset (rst_n low, synchronous): pipeline emptied, integral, previous
//   error and incremental total cleared, registers back to defaults.
module pid_speed_regulator_top #(
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pidsr_pkg::MEAS_W-1:0]          in_tdata,   // [15:0] measured
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pidsr_pkg::DRIVE_W-1:0]         out_tdata,  // [31:0] drive
  output logic                                  out_tuser,  // [0] clamped
  // configuration
  input  logic                                  cfg_we,
  input  logic [pidsr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pidsr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int FB     = GAIN_FRACTION_BITS;
  localparam int ACC_W  = (((32 + FB) > pidsr_pkg::PSUM_W) ? (32 + FB)
                                                           : pidsr_pkg::PSUM_W) + 2;
  localparam int TR_W   = ACC_W - FB;
  localparam logic [ACC_W-1:0] FRAC_MASK = {{(ACC_W-FB){1'b0}}, {FB{1'b1}}};

  localparam int ERR_W    = pidsr_pkg::ERR_W;
  localparam int DERR_W   = pidsr_pkg::DERR_W;
  localparam int ESUM_W   = pidsr_pkg::ESUM_W;
  localparam int PROD_P_W = pidsr_pkg::PROD_P_W;
  localparam int PROD_I_W = pidsr_pkg::PROD_I_W;
  localparam int PSUM_W   = pidsr_pkg::PSUM_W;

  // ---------------- configuration registers ----------------
  logic                                  law_r;
  logic signed [pidsr_pkg::SETP_W-1:0]   setpoint_r;
  logic [pidsr_pkg::GAIN_W-1:0]          gain_p_r, gain_i_r, gain_d_r;
  logic [pidsr_pkg::ILIM_W-1:0]          ilim_r;
  logic [pidsr_pkg::DLIM_W-1:0]          dlim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      law_r      <= pidsr_pkg::LAW_POSITIONAL;
      setpoint_r <= pidsr_pkg::SETPOINT_RST;
      gain_p_r   <= pidsr_pkg::GAIN_P_RST;
      gain_i_r   <= pidsr_pkg::GAIN_I_RST;
      gain_d_r   <= pidsr_pkg::GAIN_D_RST;
      ilim_r     <= pidsr_pkg::ILIM_RST;
      dlim_r     <= pidsr_pkg::DLIM_RST;
    end else if (cfg_we) begin
      case (pidsr_pkg::cfg_reg_t'(cfg_addr))
        pidsr_pkg::REG_LAW_SELECT:     law_r      <= cfg_wdata[0];
        pidsr_pkg::REG_SETPOINT:       setpoint_r <= cfg_wdata[pidsr_pkg::SETP_W-1:0];
        pidsr_pkg::REG_GAIN_P:         gain_p_r   <= cfg_wdata[pidsr_pkg::GAIN_W-1:0];
        pidsr_pkg::REG_GAIN_I:         gain_i_r   <= cfg_wdata[pidsr_pkg::GAIN_W-1:0];
        pidsr_pkg::REG_GAIN_D:         gain_d_r   <= cfg_wdata[pidsr_pkg::GAIN_W-1:0];
        pidsr_pkg::REG_INTEGRAL_LIMIT: ilim_r     <= cfg_wdata[pidsr_pkg::ILIM_W-1:0];
        pidsr_pkg::REG_DRIVE_LIMIT:    dlim_r     <= cfg_wdata[pidsr_pkg::DLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic free1, free2, free3, free4, in_acc, out_load;

  assign free4     = !out_valid_r || out_tready;
  assign free3     = !v3_r || free4;
  assign free2     = !v2_r || free3;
  assign free1     = !v1_r || free2;
  assign in_tready = free1;
  assign in_acc    = in_tvalid && free1;
  assign out_load  = v3_r && free4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free1) v1_r        <= in_tvalid;
      if (free2) v2_r        <= v1_r;
      if (free3) v3_r        <= v2_r;
      if (free4) out_valid_r <= v3_r;
    end
  end

  // ---------------- stage 1: error, integral, multiplier operands ----------------
  logic signed [ERR_W-1:0]  sp_ext, meas_ext, err;
  logic signed [DERR_W-1:0] err_ext, derr;
  logic signed [ESUM_W-1:0] err_wide, esum_sum, esum_clip, ilim_pos;
  logic signed [DERR_W-1:0] prev_err_r;
  logic signed [ESUM_W-1:0] esum_r;
  logic signed [DERR_W-1:0] op_p_r, op_p_nxt, op_d_r, op_d_nxt;
  logic signed [ESUM_W-1:0] op_i_r, op_i_nxt;

  always_comb begin
    sp_ext   = ERR_W'(setpoint_r);
    meas_ext = ERR_W'($signed(in_tdata));
    err      = (law_r == pidsr_pkg::LAW_INCREMENTAL) ? (meas_ext - sp_ext)
                                                     : (sp_ext - meas_ext);
    err_ext  = DERR_W'(err);
    err_wide = ESUM_W'(err);
    derr     = err_ext - prev_err_r;
    esum_sum = esum_r + err_wide;
    // anti-windup clamp on the stored integral
    ilim_pos = $signed({{(ESUM_W-pidsr_pkg::ILIM_W){1'b0}}, ilim_r});
    if (esum_sum > ilim_pos)       esum_clip = ilim_pos;
    else if (esum_sum < -ilim_pos) esum_clip = -ilim_pos;
    else                           esum_clip = esum_sum;
    // positional: kp*err + ki*esum + kd*derr; incremental: kp*derr + ki*err
    if (law_r == pidsr_pkg::LAW_INCREMENTAL) begin
      op_p_nxt = derr;
      op_i_nxt = err_wide;
      op_d_nxt = '0;
    end else begin
      op_p_nxt = err_ext;
      op_i_nxt = esum_sum;
      op_d_nxt = derr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r     <= '0;
      prev_err_r <= '0;
    end else if (in_acc) begin
      prev_err_r <= err_ext;
      if (law_r == pidsr_pkg::LAW_POSITIONAL) esum_r <= esum_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      op_p_r <= op_p_nxt;
      op_i_r <= op_i_nxt;
      op_d_r <= op_d_nxt;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [PROD_P_W-1:0] prod_p_r, prod_d_r;
  logic signed [PROD_I_W-1:0] prod_i_r;

  always_ff @(posedge clk) begin
    if (free2) begin
      prod_p_r <= op_p_r * $signed({1'b0, gain_p_r});
      prod_i_r <= op_i_r * $signed({1'b0, gain_i_r});
      prod_d_r <= op_d_r * $signed({1'b0, gain_d_r});
    end
  end

  // ---------------- stage 3: product sum ----------------
  logic signed [PSUM_W-1:0] psum_r;

  always_ff @(posedge clk) begin
    if (free3) begin
      psum_r <= PSUM_W'(prod_p_r) + PSUM_W'(prod_i_r) + PSUM_W'(prod_d_r);
    end
  end

  // ---------------- stage 4: accumulate, truncate, clamp ----------------
  logic signed [31:0]       total_r;
  logic signed [ACC_W-1:0]  acc_base, acc, acc_rnd;
  logic signed [TR_W-1:0]   trunc_val, dlim_pos, i32_max, i32_min;
  logic [31:0]              drive_nxt;
  logic                     clamp_nxt;

  always_comb begin
    acc_base = (law_r == pidsr_pkg::LAW_INCREMENTAL)
             ? $signed({{(ACC_W-32-FB){total_r[31]}}, total_r, {FB{1'b0}}})
             : '0;
    acc      = acc_base + ACC_W'(psum_r);
    // truncate toward zero: bias negatives by the fraction mask before the shift
    acc_rnd  = acc + (acc[ACC_W-1] ? $signed(FRAC_MASK) : '0);
    trunc_val = acc_rnd[ACC_W-1:FB];
    dlim_pos  = $signed({{(TR_W-pidsr_pkg::DLIM_W){1'b0}}, dlim_r});
    i32_max   = TR_W'(32'sh7fff_ffff);
    i32_min   = ~i32_max;
    clamp_nxt = 1'b0;
    if (law_r == pidsr_pkg::LAW_INCREMENTAL) begin
      if (trunc_val > i32_max) begin
        drive_nxt = 32'h7fff_ffff;
        clamp_nxt = 1'b1;
      end else if (trunc_val < i32_min) begin
        drive_nxt = 32'h8000_0000;
        clamp_nxt = 1'b1;
      end else begin
        drive_nxt = trunc_val[31:0];
      end
    end else begin
      if (trunc_val > dlim_pos) begin
        drive_nxt = dlim_pos[31:0];
        clamp_nxt = 1'b1;
      end else if (trunc_val < -dlim_pos) begin
        drive_nxt = 32'(-dlim_pos);
        clamp_nxt = 1'b1;
      end else begin
        drive_nxt = trunc_val[31:0];
      end
    end
  end

  // incremental accumulator closes its loop here, one result per cycle when the output can load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (out_load && (law_r == pidsr_pkg::LAW_INCREMENTAL)) begin
      total_r <= $signed(drive_nxt);
    end
  end

  logic [31:0] out_data_r;
  logic        out_user_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= drive_nxt;
      out_user_r <= clamp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/pidsr_checker.sv
// Port-level checker for the PID speed regulator and its bind.
module pidsr_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [pidsr_pkg::DRIVE_W-1:0]        out_tdata,
  input logic                                 out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a result appearing on an empty output came from an accepted input transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 4))
    else $error("result without matching input transaction");

  // with the sink ready the pipeline never pushes back on the source
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output ready");

endmodule

bind pid_speed_regulator_top pidsr_checker u_pidsr_checker (.*);

FILE: sim/tb_top.sv
// Self-checking stream testbench for the PID speed regulator (both control laws).
`timescale 1ns / 100ps

module tb_top;

  localparam int  CLK_PERIOD   = 12;
  localparam int  RESET_CYCLES = 9;
  localparam int  FRAC_BITS    = 16;
  // pipeline is 4 deep; give it a little more before touching registers
  localparam int  SETTLE_CYCLES = 8;
  // cycles without any transaction before the run is declared hung
  localparam int  STALL_LIMIT  = 2000;
  // index past the register map, must be ignored by the block
  localparam logic [pidsr_pkg::CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  localparam longint DRIVE_MAX = (longint'(1) <<< 31) - 1;
  localparam longint DRIVE_MIN = -(longint'(1) <<< 31);

  typedef struct packed {
    logic [pidsr_pkg::DRIVE_W-1:0] drive;
    logic                          clamped;
  } drive_t;

  // DUT inputs, all at known values from time zero
  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [pidsr_pkg::MEAS_W-1:0]     in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [pidsr_pkg::DRIVE_W-1:0]    out_tdata;
  logic                             out_tuser;
  logic                             cfg_we     = 1'b0;
  logic [pidsr_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [pidsr_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  // samples waiting to be sent, and drive values waiting to come back
  logic [pidsr_pkg::MEAS_W-1:0] sample_q[$];
  drive_t                       expected_q[$];
  drive_t                       want;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int fail_cnt    = 0;
  int quiet_cycles = 0;

  // shadow copy of the register file
  logic   m_law;
  longint m_setp, m_gp, m_gi, m_gd, m_ilim, m_dlim;
  // shadow copy of the loop state
  longint m_esum, m_prev_err, m_total;

  pid_speed_regulator_top #(
    .GAIN_FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] measured
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] drive
    .out_tuser  (out_tuser),   // [0] clamped
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Fixed-point to integer, rounding toward zero.
  function automatic longint trunc_gain(input longint v);
    if (v < 0)
      return -((-v) >>> FRAC_BITS);
    return v >>> FRAC_BITS;
  endfunction

  // One control step: updates the shadow state, returns the drive it yields.
  function automatic drive_t regulate_step(
    input logic signed [pidsr_pkg::MEAS_W-1:0] meas
  );
    longint m, err, acc, drv;
    drive_t r;
    m = meas;
    r.clamped = 1'b0;
    if (m_law == pidsr_pkg::LAW_POSITIONAL) begin
      err    = m_setp - m;
      m_esum = m_esum + err;
      acc    = m_gp * err + m_gi * m_esum + m_gd * (err - m_prev_err);
      drv    = trunc_gain(acc);
      if (drv > m_dlim) begin
        drv = m_dlim;
        r.clamped = 1'b1;
      end else if (drv < -m_dlim) begin
        drv = -m_dlim;
        r.clamped = 1'b1;
      end
      // anti-windup: integral clamp applies after the output is formed
      if (m_esum > m_ilim)
        m_esum = m_ilim;
      else if (m_esum < -m_ilim)
        m_esum = -m_ilim;
    end else begin
      err = m - m_setp;
      // truncation applies to the new total, not to the increment
      acc = (m_total <<< FRAC_BITS) + m_gp * (err - m_prev_err) + m_gi * err;
      drv = trunc_gain(acc);
      if (drv > DRIVE_MAX) begin
        drv = DRIVE_MAX;
        r.clamped = 1'b1;
      end else if (drv < DRIVE_MIN) begin
        drv = DRIVE_MIN;
        r.clamped = 1'b1;
      end
      m_total = drv;
    end
    // previous error is shared by both laws
    m_prev_err = err;
    r.drive = 32'(drv);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds sample_q onto the input stream with random gaps.
  // Predicts at the edge where the transaction is taken, so the shadow
  // registers are always the ones the block used.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(regulate_step(in_tdata));
      if (in_tvalid && !in_tready) begin
        // stalled: hold valid and data steady
      end else if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= sample_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure on the result stream, in-order compare.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: drive %0d, clamped %0b",
                 $signed(out_tdata), out_tuser);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata !== want.drive) begin
            $error("drive mismatch: expected %0d, actual %0d",
                   $signed(want.drive), $signed(out_tdata));
            fail_cnt++;
          end
          if (out_tuser !== want.clamped) begin
            $error("clamped mismatch: expected %0b, actual %0b", want.clamped, out_tuser);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: any transaction on either stream restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and sequencing
  // ---------------------------------------------------------------------------

  // One-cycle register write; the shadow copy follows it.
  task automatic cfg_write(input logic [pidsr_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      pidsr_pkg::REG_LAW_SELECT:     m_law  = val[0];
      pidsr_pkg::REG_SETPOINT:       m_setp = longint'($signed(val[pidsr_pkg::SETP_W-1:0]));
      pidsr_pkg::REG_GAIN_P:         m_gp   = longint'(val);
      pidsr_pkg::REG_GAIN_I:         m_gi   = longint'(val);
      pidsr_pkg::REG_GAIN_D:         m_gd   = longint'(val);
      pidsr_pkg::REG_INTEGRAL_LIMIT: m_ilim = longint'(val[pidsr_pkg::ILIM_W-1:0]);
      pidsr_pkg::REG_DRIVE_LIMIT:    m_dlim = longint'(val[pidsr_pkg::DLIM_W-1:0]);
      default: ;  // out-of-map index: no effect
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender holds off until every sample is in and every result is back,
  // then lets the pipeline go quiet before any register write.
  task automatic settle();
    do
      @(negedge clk);
    while (sample_q.size() != 0 || in_tvalid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(24'h0FFFFF));  // up to 16.0
    endcase
  endfunction

  task automatic random_setup();
    logic [pidsr_pkg::SETP_W-1:0] sp;
    logic [pidsr_pkg::ILIM_W-1:0] il;
    logic [pidsr_pkg::DLIM_W-1:0] dl;
    case ($urandom_range(3))
      0:       sp = 16'h8000;
      1:       sp = 16'h7FFF;
      2:       sp = 16'($urandom);
      default: sp = 16'($urandom_range(2000) - 1000);
    endcase
    case ($urandom_range(4))
      0:       il = '0;
      1:       il = 20'hFFFFF;
      2:       il = 20'($urandom);
      default: il = 20'($urandom_range(10000));
    endcase
    case ($urandom_range(4))
      0:       dl = '0;
      1:       dl = 16'hFFFF;
      2:       dl = 16'($urandom);
      default: dl = 16'($urandom_range(2000));
    endcase
    cfg_write(pidsr_pkg::REG_LAW_SELECT, 24'($urandom_range(1)));
    cfg_write(pidsr_pkg::REG_SETPOINT, {8'h00, sp});
    cfg_write(pidsr_pkg::REG_GAIN_P, pick_gain());
    cfg_write(pidsr_pkg::REG_GAIN_I, pick_gain());
    cfg_write(pidsr_pkg::REG_GAIN_D, pick_gain());
    cfg_write(pidsr_pkg::REG_INTEGRAL_LIMIT, {4'h0, il});
    cfg_write(pidsr_pkg::REG_DRIVE_LIMIT, {8'h00, dl});
  endtask

  // A block of samples in one of several shapes: noise, small errors around
  // the setpoint, pinned at a rail, or held steps of random height.
  task automatic queue_chunk(input int n);
    int                           style;
    int                           run;
    longint                       v;
    logic [pidsr_pkg::MEAS_W-1:0] level;
    style = $urandom_range(3);
    run   = 0;
    level = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: sample_q.push_back(16'($urandom));
        1: begin
          v = m_setp + longint'($urandom_range(400)) - 200;
          if (v > 32767)
            v = 32767;
          else if (v < -32768)
            v = -32768;
          sample_q.push_back(16'(v));
        end
        2: sample_q.push_back(($urandom_range(15) == 0) ? 16'($urandom) : level);
        default: begin
          if (run == 0) begin
            level = 16'($urandom);
            run   = $urandom_range(30, 5);
          end
          run--;
          sample_q.push_back(level);
        end
      endcase
    end
  endtask

  // Incremental law at full gains against the far rail: long enough to carry
  // the total from one 32-bit limit to the other and sit in saturation.
  task automatic saturate_total(input logic upward);
    cfg_write(pidsr_pkg::REG_LAW_SELECT, 24'(pidsr_pkg::LAW_INCREMENTAL));
    cfg_write(pidsr_pkg::REG_SETPOINT, upward ? 24'h008000 : 24'h007FFF);
    cfg_write(pidsr_pkg::REG_GAIN_P, 24'hFFFFFF);
    cfg_write(pidsr_pkg::REG_GAIN_I, 24'hFFFFFF);
    repeat (260) sample_q.push_back(upward ? 16'h7FFF : 16'h8000);
    settle();
  endtask

  initial begin
    // shadow state matches the block's reset values
    m_law      = pidsr_pkg::LAW_POSITIONAL;
    m_setp     = longint'($signed(pidsr_pkg::SETPOINT_RST));
    m_gp       = longint'(pidsr_pkg::GAIN_P_RST);
    m_gi       = longint'(pidsr_pkg::GAIN_I_RST);
    m_gd       = longint'(pidsr_pkg::GAIN_D_RST);
    m_ilim     = longint'(pidsr_pkg::ILIM_RST);
    m_dlim     = longint'(pidsr_pkg::DLIM_RST);
    m_esum     = 0;
    m_prev_err = 0;
    m_total    = 0;

    tx_idle_pct = 34;
    rx_idle_pct = 76;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset defaults, positional law. Rails, zero error, single
    // LSB either side, alternating bit patterns. The rails drive the
    // integral into its clamp.
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'd50);
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h0001);
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h5555);
    sample_q.push_back(16'hAAAA);
    settle();

    // Full-scale gains and limits, setpoint on the negative rail; the
    // derivative term swings across the largest error step.
    cfg_write(pidsr_pkg::REG_SETPOINT, 24'h008000);
    cfg_write(pidsr_pkg::REG_GAIN_P, 24'hFFFFFF);
    cfg_write(pidsr_pkg::REG_GAIN_I, 24'hFFFFFF);
    cfg_write(pidsr_pkg::REG_GAIN_D, 24'hFFFFFF);
    cfg_write(pidsr_pkg::REG_INTEGRAL_LIMIT, 24'h0FFFFF);
    cfg_write(pidsr_pkg::REG_DRIVE_LIMIT, 24'h00FFFF);
    cfg_write(REG_SPARE, 24'hFFFFFF);
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'h0000);
    settle();

    // Zero limits: drive forced to zero, integral wiped every step.
    cfg_write(pidsr_pkg::REG_SETPOINT, 24'h007FFF);
    cfg_write(pidsr_pkg::REG_DRIVE_LIMIT, 24'h000000);
    cfg_write(pidsr_pkg::REG_INTEGRAL_LIMIT, 24'h000000);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'd100);
    settle();

    // Switch to the incremental law with no state clear; previous error
    // carries over from the positional steps.
    cfg_write(pidsr_pkg::REG_LAW_SELECT, 24'(pidsr_pkg::LAW_INCREMENTAL));
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'h0000);
    settle();

    // Random part, three idling regimes. Each block of samples ends in a
    // full drain, so the sender repeatedly waits for every result.
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 76;
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      saturate_total(regime != 1);
      repeat (4) begin
        random_setup();
        queue_chunk(85);
        settle();
      end
    end

    settle();
    if (fail_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
